### rtl/core/image_header_size_sniffer_defines.svh
// Assertion macros for the image header size sniffer.
// Included by the top level; no other dependencies.
`ifndef IMAGE_HEADER_SIZE_SNIFFER_DEFINES_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_DEFINES_SVH
`ifndef SYNTHESIS
`define IHS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("ihs implication check failed");
`define IHS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("ihs next-cycle check failed");
`else
`define IHS_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define IHS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/core/ihs_pkg.sv
// Package for the image header size sniffer: window size, widths, word types,
// format codes and the JPEG start-of-frame decode. No dependencies.
package ihs_pkg;

	localparam int WINDOW = 1024;
	localparam int POS_W  = $clog2(WINDOW);
	// GIF descriptor base reaches 13 + 3 * 256
	localparam int BASE_W = (POS_W > 10) ? POS_W : 10;

	localparam logic [7:0]        MARK_FF     = 8'hff;
	localparam logic [23:0]       SIG_GIF     = 24'h464947;
	localparam logic [23:0]       SIG_PNG     = 24'h474e50;
	localparam logic [BASE_W-1:0] GIF_HDR_LEN = BASE_W'(13);

	typedef enum logic [1:0] {
		FMT_UNKNOWN = 2'd0,
		FMT_JPEG    = 2'd1,
		FMT_GIF     = 2'd2,
		FMT_PNG     = 2'd3
	} ihs_fmt_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} ihs_in_t;

	typedef struct packed {
		ihs_fmt_t    image_format;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic        size_valid;
	} ihs_out_t;

	// SOF0..SOF15 minus DHT, JPG and DAC
	function automatic logic is_sof(input logic [7:0] b);
		return (b[7:4] == 4'hc) && (b[3:0] != 4'h4) && (b[3:0] != 4'h8) &&
			(b[3:0] != 4'hc);
	endfunction

endpackage

### rtl/core/ihs_in_stage.sv
// Input register stage of the image header size sniffer.
// Depends on ihs_pkg for the input word type.
module ihs_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ihs_pkg::ihs_in_t in_data,
	input  logic           advance,
	output logic           s1_valid,
	output ihs_pkg::ihs_in_t s1_data
);

	logic             valid_s1;
	ihs_pkg::ihs_in_t data_s1;
	logic             accept;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

endmodule

### rtl/core/ihs_parse.sv
// Header parser of the image header size sniffer: per-file state and the
// one-byte update. Depends on ihs_pkg.
module ihs_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  ihs_pkg::ihs_in_t  item,
	input  logic              enable,
	output logic              emit,
	output ihs_pkg::ihs_out_t result
);

	logic [ihs_pkg::POS_W-1:0]  pos_q;
	ihs_pkg::ihs_fmt_t          fmt_q;
	logic [31:0]                sig_q;
	logic                       prev_ff_q;
	logic                       marker_q;
	logic [ihs_pkg::BASE_W-1:0] base_q;
	logic [31:0]                wid_q;
	logic [31:0]                hgt_q;
	logic                       done_q;

	ihs_pkg::ihs_fmt_t          tk_fmt;
	logic [31:0]                tk_sig;
	logic                       tk_prev_ff;
	logic                       tk_marker;
	logic [ihs_pkg::BASE_W-1:0] tk_base;
	logic [31:0]                tk_wid;
	logic [31:0]                tk_hgt;
	logic [ihs_pkg::BASE_W-1:0] p_ext;
	logic [ihs_pkg::BASE_W-1:0] off;
	logic                       past_base;
	logic [ihs_pkg::BASE_W-1:0] gif_base;
	logic [7:0]                 b;

	assign b         = item.data_byte;
	assign p_ext     = ihs_pkg::BASE_W'(pos_q);
	assign off       = p_ext - base_q;
	assign past_base = p_ext > base_q;
	assign gif_base  = ihs_pkg::GIF_HDR_LEN +
		(b[7] ? (ihs_pkg::BASE_W'(3) << ({1'b0, b[2:0]} + 4'd1)) : '0);

	assign emit = !done_q &&
		(item.end_of_file || (pos_q >= ihs_pkg::POS_W'(ihs_pkg::WINDOW - 1)));

	always_comb begin
		tk_sig     = sig_q;
		tk_fmt     = fmt_q;
		tk_prev_ff = prev_ff_q;
		tk_marker  = marker_q;
		tk_base    = base_q;
		tk_wid     = wid_q;
		tk_hgt     = hgt_q;

		if (pos_q < ihs_pkg::POS_W'(4)) begin
			tk_sig[{pos_q[1:0], 3'b000} +: 8] = b;
		end
		if (pos_q == '0 && b == ihs_pkg::MARK_FF) begin
			tk_fmt = ihs_pkg::FMT_JPEG;
		end
		if (pos_q == ihs_pkg::POS_W'(2) && tk_fmt == ihs_pkg::FMT_UNKNOWN &&
			tk_sig[23:0] == ihs_pkg::SIG_GIF) begin
			tk_fmt = ihs_pkg::FMT_GIF;
		end
		if (pos_q == ihs_pkg::POS_W'(3) && tk_fmt == ihs_pkg::FMT_UNKNOWN &&
			tk_sig[31:8] == ihs_pkg::SIG_PNG) begin
			tk_fmt = ihs_pkg::FMT_PNG;
		end

		case (tk_fmt)
			ihs_pkg::FMT_JPEG: begin
				if (!marker_q) begin
					if (prev_ff_q && ihs_pkg::is_sof(b)) begin
						tk_marker = 1'b1;
						tk_base   = p_ext - ihs_pkg::BASE_W'(1);
					end
					tk_prev_ff = (b == ihs_pkg::MARK_FF);
				end else if (past_base) begin
					if (off == ihs_pkg::BASE_W'(5)) tk_hgt[15:8] = hgt_q[15:8] | b;
					else if (off == ihs_pkg::BASE_W'(6)) tk_hgt[7:0] = hgt_q[7:0] | b;
					else if (off == ihs_pkg::BASE_W'(7)) tk_wid[15:8] = wid_q[15:8] | b;
					else if (off == ihs_pkg::BASE_W'(8)) tk_wid[7:0] = wid_q[7:0] | b;
				end
			end
			ihs_pkg::FMT_GIF: begin
				if (pos_q == ihs_pkg::POS_W'(10)) begin
					tk_base   = gif_base;
					tk_marker = 1'b1;
				end else if (marker_q && past_base) begin
					if (off == ihs_pkg::BASE_W'(5)) tk_wid[7:0] = wid_q[7:0] | b;
					else if (off == ihs_pkg::BASE_W'(6)) tk_wid[15:8] = wid_q[15:8] | b;
					else if (off == ihs_pkg::BASE_W'(7)) tk_hgt[7:0] = hgt_q[7:0] | b;
					else if (off == ihs_pkg::BASE_W'(8)) tk_hgt[15:8] = hgt_q[15:8] | b;
				end
			end
			ihs_pkg::FMT_PNG: begin
				case (pos_q)
					ihs_pkg::POS_W'(16): tk_wid[31:24] = wid_q[31:24] | b;
					ihs_pkg::POS_W'(17): tk_wid[23:16] = wid_q[23:16] | b;
					ihs_pkg::POS_W'(18): tk_wid[15:8]  = wid_q[15:8] | b;
					ihs_pkg::POS_W'(19): tk_wid[7:0]   = wid_q[7:0] | b;
					ihs_pkg::POS_W'(20): tk_hgt[31:24] = hgt_q[31:24] | b;
					ihs_pkg::POS_W'(21): tk_hgt[23:16] = hgt_q[23:16] | b;
					ihs_pkg::POS_W'(22): tk_hgt[15:8]  = hgt_q[15:8] | b;
					ihs_pkg::POS_W'(23): tk_hgt[7:0]   = hgt_q[7:0] | b;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		if (enable) begin
			result.image_format = tk_fmt;
			result.image_width  = tk_wid;
			result.image_height = tk_hgt;
			result.size_valid   = (tk_wid != '0) && (tk_hgt != '0);
		end else begin
			result.image_format = ihs_pkg::FMT_UNKNOWN;
			result.image_width  = '0;
			result.image_height = '0;
			result.size_valid   = 1'b0;
		end
	end

	// end of file clears everything, reported or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fmt_q     <= ihs_pkg::FMT_UNKNOWN;
			sig_q     <= '0;
			prev_ff_q <= 1'b0;
			marker_q  <= 1'b0;
			base_q    <= '0;
			wid_q     <= '0;
			hgt_q     <= '0;
			done_q    <= 1'b0;
		end else if (step) begin
			if (item.end_of_file) begin
				pos_q     <= '0;
				fmt_q     <= ihs_pkg::FMT_UNKNOWN;
				sig_q     <= '0;
				prev_ff_q <= 1'b0;
				marker_q  <= 1'b0;
				base_q    <= '0;
				wid_q     <= '0;
				hgt_q     <= '0;
				done_q    <= 1'b0;
			end else if (!done_q) begin
				fmt_q     <= tk_fmt;
				sig_q     <= tk_sig;
				prev_ff_q <= tk_prev_ff;
				marker_q  <= tk_marker;
				base_q    <= tk_base;
				wid_q     <= tk_wid;
				hgt_q     <= tk_hgt;
				if (emit) begin
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + ihs_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule

### rtl/core/ihs_out_reg.sv
// Result register of the image header size sniffer.
// Depends on ihs_pkg for the result word type.
module ihs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ihs_pkg::ihs_out_t load_data,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output ihs_pkg::ihs_out_t out_data
);

	logic              valid_q;
	ihs_pkg::ihs_out_t data_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### rtl/core/image_header_size_sniffer.sv
// Image header size sniffer: one file byte per word, one size word per file.
// A byte with end of file (or byte WINDOW-1) is registered in the input stage; its size
// word then goes into the result register. Throughput: one byte per cycle, set
// by the one-byte parser update; only a stalled size word against a reporting byte
// stalls input. Reset (arst_n, async, active low) clears all file state and sets
// enable_q to one. Depends on ihs_pkg, the three stages and the defines header.
`include "image_header_size_sniffer_defines.svh"
module image_header_size_sniffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ihs_pkg::ihs_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ihs_pkg::ihs_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	logic              enable_q;
	logic              s1_valid;
	ihs_pkg::ihs_in_t  s1_data;
	logic              advance;
	logic              emit;
	logic              load;
	logic              out_free;
	ihs_pkg::ihs_out_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	assign advance = s1_valid && (!emit || out_free);
	assign load    = advance && emit;

	ihs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_data  (s1_data)
	);

	ihs_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (s1_data),
		.enable (enable_q),
		.emit   (emit),
		.result (result)
	);

	ihs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`IHS_ASSERT_IMPLIES(a_no_load_when_held, clk, arst_n, out_valid && out_stall, !load)
	`IHS_ASSERT_IMPLIES(a_stall_needs_item, clk, arst_n, in_stall, s1_valid)
	`IHS_ASSERT_NEXT(a_load_shows, clk, arst_n, load, out_valid)
	`IHS_ASSERT_IMPLIES(a_size_nonzero, clk, arst_n, out_valid && out_data.size_valid, (out_data.image_width != '0) && (out_data.image_height != '0))

endmodule
